FILE: hw/rtl/rtp_pkg.sv
// Shared types, constants and the arctangent table for the rectangular-to-polar block.
// No dependencies; every other file imports this package.
package rtp_pkg;

  // Default parameter values
  localparam int COORD_WIDTH_DEF  = 16;
  localparam int ANGLE_STAGES_DEF = 16;

  // CORDIC datapath: 60-bit scaled magnitude plus room for gain and sign
  localparam int CORDIC_W = 62;
  localparam int SCALE_TOP = 60;

  // Angle accumulator: 32-bit binary angle, one full turn is 2^32
  localparam int ACC_W   = 32;
  localparam int ANGLE_W = 16;
  localparam logic [ACC_W-1:0] PI_TURN    = 32'h8000_0000;
  localparam logic [ACC_W-1:0] ROUND_HALF = 32'h0000_8000;

  // One CORDIC vector in flight
  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic [ACC_W-1:0]           z;
  } cordic_t;

  // atan(2^-i) in binary-angle units, rounded to nearest
  function automatic logic [ACC_W-1:0] atan_turn(input logic [4:0] idx);
    logic [ACC_W-1:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/rtp_cordic_stage.sv
// One vectoring-mode CORDIC micro-rotation with its pipeline register.
// Depends on rtp_pkg for the vector type and the arctangent table.
module rtp_cordic_stage #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             en,
  input  rtp_pkg::cordic_t vec_in,
  output rtp_pkg::cordic_t vec_r
);
  import rtp_pkg::*;

  localparam logic [ACC_W-1:0] ATAN = atan_turn(5'(STAGE));

  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  cordic_t                    vec_nxt;

  // Floor shift, then rotate toward the x axis
  always_comb begin
    xs = vec_in.x >>> STAGE;
    ys = vec_in.y >>> STAGE;
    if (vec_in.y[CORDIC_W-1]) begin
      vec_nxt.x = vec_in.x - ys;
      vec_nxt.y = vec_in.y + xs;
      vec_nxt.z = vec_in.z - ATAN;
    end else begin
      vec_nxt.x = vec_in.x + ys;
      vec_nxt.y = vec_in.y - xs;
      vec_nxt.z = vec_in.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

endmodule

FILE: hw/rtl/rtp_sqrt_stage.sv
// One digit step of the restoring integer square root, with its pipeline register.
// Depends on rtp_pkg for the default COORD_WIDTH and through the import; widths follow COORD_WIDTH.
module rtp_sqrt_stage #(
  parameter int COORD_WIDTH = rtp_pkg::COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [COORD_WIDTH:0]     rem_in,
  input  logic [COORD_WIDTH-1:0]   root_in,
  input  logic [2*COORD_WIDTH-1:0] rad_in,
  output logic [COORD_WIDTH:0]     rem_r,
  output logic [COORD_WIDTH-1:0]   root_r,
  output logic [2*COORD_WIDTH-1:0] rad_r
);
  import rtp_pkg::*;

  localparam int W = COORD_WIDTH;

  logic [W+2:0]   cur;
  logic [W+2:0]   trial;
  logic [W+2:0]   diff;
  logic           fits;
  logic [W:0]     rem_nxt;
  logic [W-1:0]   root_nxt;
  logic [2*W-1:0] rad_nxt;

  // Bring down the next two bits and try root*4+1
  always_comb begin
    cur      = {rem_in, rad_in[2*W-1 -: 2]};
    trial    = {1'b0, root_in, 2'b01};
    diff     = cur - trial;
    fits     = (cur >= trial);
    rem_nxt  = fits ? diff[W:0] : cur[W:0];
    root_nxt = {root_in[W-2:0], fits};
    rad_nxt  = {rad_in[2*W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_nxt;
    end
  end

endmodule

FILE: hw/rtl/rtp_out_buf.sv
// Output register plus skid register between the pipeline and the result channel.
// Depends on rtp_pkg through the import convention only.
module rtp_out_buf #(
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pipe_vld,
  input  logic [DATA_W-1:0] pipe_data,
  output logic              adv,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata
);
  import rtp_pkg::*;

  logic              out_v_r;
  logic              skid_v_r;
  logic [DATA_W-1:0] out_d_r;
  logic [DATA_W-1:0] skid_d_r;
  logic              take;

  // Pipeline moves while the skid slot is free
  assign adv        = !skid_v_r;
  assign take       = out_v_r && out_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        skid_v_r <= 1'b0;
      end
    end else if (out_v_r && !out_tready) begin
      skid_v_r <= pipe_vld;
    end else begin
      out_v_r <= pipe_vld;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) begin
        out_d_r <= skid_d_r;
      end
    end else if (out_v_r && !out_tready) begin
      skid_d_r <= pipe_data;
    end else begin
      out_d_r <= pipe_data;
    end
  end

  // A filled skid slot always sits behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid slot full with empty output register");

  // A stalled, full buffer stays full
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_tready) |=> skid_v_r)
    else $error("skid request lost under stall");

  // Draining the skid slot refills the output register
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_tready) |=> (out_v_r && !skid_v_r))
    else $error("skid drain did not move request to output");

endmodule

FILE: hw/rtl/rectangular_to_polar.sv
// Rectangular-to-polar converter top level: input prep, unrolled CORDIC and root stages.
// Depends on rtp_pkg, rtp_cordic_stage, rtp_sqrt_stage and rtp_out_buf.
//
// Converts one (x, y) point per clock, while the skid slot is free, into radius =
// floor(sqrt(x*x + y*y)) and angle = atan2(y, x) as a 16-bit binary angle (32768 = pi,
// +pi reads as -32768, origin gives 0). A new point is taken every cycle unless the
// skid slot of the output buffer is full. The accepting edge loads the squaring and
// quadrant folding register, then the sum of squares is registered, then each CORDIC
// micro-rotation and root digit has its own register (the two run side by side, so the
// longer of the two sets the depth), then the output register. A two-entry output buffer
// keeps accepting points while one result waits.
module rectangular_to_polar #(
  parameter int  COORD_WIDTH  = rtp_pkg::COORD_WIDTH_DEF,
  parameter int  ANGLE_STAGES = rtp_pkg::ANGLE_STAGES_DEF,
  localparam int IN_DW  = 8 * ((2 * COORD_WIDTH + 7) / 8),
  localparam int OUT_DW = 8 * ((COORD_WIDTH + rtp_pkg::ANGLE_W + 7) / 8)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // x_coord, y_coord, zero pad
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata   // radius, angle, zero pad
);
  import rtp_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int N     = (ANGLE_STAGES > W) ? ANGLE_STAGES : W;
  localparam int FRAC  = SCALE_TOP - W;
  localparam int EXT   = CORDIC_W - FRAC - (W + 1);

  logic adv;

  // ---------------- Prep stage: fold quadrant, square magnitudes
  logic signed [W-1:0] x_in;
  logic signed [W-1:0] y_in;
  logic                neg;
  logic [W-1:0]        ax;
  logic [W-1:0]        ay;
  logic signed [W:0]   xn;
  logic signed [W:0]   yn;
  cordic_t             cor_nxt;

  logic [2*W-1:0]      sqx_r;
  logic [2*W-1:0]      sqy_r;
  cordic_t             cor0_r;
  logic                zero0_r;
  logic                v0_r;

  assign in_tready = adv;

  always_comb begin
    x_in = in_tdata[W-1:0];
    y_in = in_tdata[2*W-1:W];
    neg  = x_in[W-1];
    ax   = x_in[W-1] ? (~x_in + 1'b1) : x_in;
    ay   = y_in[W-1] ? (~y_in + 1'b1) : y_in;
    xn   = neg ? -{x_in[W-1], x_in} : {x_in[W-1], x_in};
    yn   = neg ? -{y_in[W-1], y_in} : {y_in[W-1], y_in};
    cor_nxt.x = {{EXT{xn[W]}}, xn, {FRAC{1'b0}}};
    cor_nxt.y = {{EXT{yn[W]}}, yn, {FRAC{1'b0}}};
    cor_nxt.z = neg ? PI_TURN : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r   <= ax * ax;
      sqy_r   <= ay * ay;
      cor0_r  <= cor_nxt;
      zero0_r <= (x_in == '0) && (y_in == '0);
    end
  end

  // ---------------- Valid chain
  logic [N:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      vld_r <= '0;
    end else if (adv) begin
      v0_r  <= in_tvalid;
      vld_r <= {vld_r[N-1:0], v0_r};
    end
  end

  // ---------------- Sum stage
  cordic_t        cor_c  [0:N];
  logic [W:0]     rem_c  [0:N];
  logic [W-1:0]   root_c [0:N];
  logic [2*W-1:0] rad_c  [0:N];
  logic           zero_c [0:N];

  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      cor_c[0]  <= cor0_r;
      rad_c[0]  <= sqx_r + sqy_r;
      zero_c[0] <= zero0_r;
    end
  end

  // ---------------- Iteration stages
  for (genvar k = 0; k < N; k++) begin : g_iter
    if (k < ANGLE_STAGES) begin : g_rot
      rtp_cordic_stage #(.STAGE(k)) u_rot (
        .clk    (clk),
        .en     (adv),
        .vec_in (cor_c[k]),
        .vec_r  (cor_c[k+1])
      );
    end else begin : g_rot_hold
      always_ff @(posedge clk) begin
        if (adv) begin
          cor_c[k+1] <= cor_c[k];
        end
      end
    end

    if (k < W) begin : g_root
      rtp_sqrt_stage #(.COORD_WIDTH(W)) u_root (
        .clk     (clk),
        .en      (adv),
        .rem_in  (rem_c[k]),
        .root_in (root_c[k]),
        .rad_in  (rad_c[k]),
        .rem_r   (rem_c[k+1]),
        .root_r  (root_c[k+1]),
        .rad_r   (rad_c[k+1])
      );
    end else begin : g_root_hold
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_c[k+1]  <= rem_c[k];
          root_c[k+1] <= root_c[k];
          rad_c[k+1]  <= rad_c[k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        zero_c[k+1] <= zero_c[k];
      end
    end
  end

  // ---------------- Angle rounding and result packing
  logic [ACC_W-1:0]   z_rnd;
  logic [ANGLE_W-1:0] angle;
  logic [OUT_DW-1:0]  res_data;

  always_comb begin
    z_rnd    = cor_c[N].z + ROUND_HALF;
    angle    = zero_c[N] ? '0 : z_rnd[ACC_W-1 -: ANGLE_W];
    res_data = OUT_DW'({angle, root_c[N]});
  end

  rtp_out_buf #(.DATA_W(OUT_DW)) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .pipe_vld   (vld_r[N]),
    .pipe_data  (res_data),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Zero radius only comes from the origin, which reports angle zero
  a_origin_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[W-1:0] == '0)) |-> (out_tdata[W+ANGLE_W-1:W] == '0))
    else $error("zero radius with nonzero angle");

  // Stalled pipeline keeps its valid bits
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && $stable(v0_r))
    else $error("pipeline valid bits moved during stall");

  // An accepted request enters the prep stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v0_r)
    else $error("accepted request missing from prep stage");

endmodule
